FILE: hdl/mdd_pkg.sv
// shared types and constants of the multiplexed digit display scanner
// no dependencies; imported by every module of the block
`default_nettype none

package mdd_pkg;

  // full pwm period in ticks, off time plus on time of one digit
  localparam int BRIGHT_MAX  = 255;
  localparam int DIGIT_COUNT = 4;
  localparam int DIG_W       = $clog2(DIGIT_COUNT);
  localparam int CODE_W      = 8;
  localparam int BRIGHT_W    = 8;
  localparam int CHAR_W      = 8;

  // phase timer width: holds BRIGHT_MAX and any brightness value
  localparam int LEN_W = ($clog2(BRIGHT_MAX + 1) > BRIGHT_W) ?
                         $clog2(BRIGHT_MAX + 1) : BRIGHT_W;

  localparam logic [BRIGHT_W-1:0] BRIGHT_RST =
    BRIGHT_W'((BRIGHT_MAX > 255) ? 255 : BRIGHT_MAX);
  localparam logic [LEN_W-1:0]    BRIGHT_MAX_L = LEN_W'(BRIGHT_MAX);

  localparam logic [CODE_W-1:0] BLANK_CODE = 8'hFF;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 8'h39;

  // input kinds carried on tuser
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  localparam int CFG_ADDR_W = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BRIGHT0    = 3'd0,
    REG_BRIGHT1    = 3'd1,
    REG_BRIGHT2    = 3'd2,
    REG_BRIGHT3    = 3'd3,
    REG_DISPLAY_ON = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic                  we;
    logic [CFG_ADDR_W-1:0] addr;
    logic [BRIGHT_W-1:0]   data;
  } cfg_wr_t;

  // decoded load: one code per digit plus blank flags
  typedef struct packed {
    logic [DIGIT_COUNT-1:0][CODE_W-1:0] codes;
    logic [DIGIT_COUNT-1:0]             blank;
  } load_t;

  typedef struct packed {
    logic [DIG_W-1:0]       scan_digit;
    logic [DIGIT_COUNT-1:0] anode_lines;
    logic [CODE_W-1:0]      cathode_code;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/mdd_char_decode.sv
// ascii to digit code decoder for one load beat
// depends on mdd_pkg
`default_nettype none

module mdd_char_decode (
  input  logic [mdd_pkg::DIGIT_COUNT-1:0][mdd_pkg::CHAR_W-1:0] chars_i,
  output mdd_pkg::load_t                                       load_o
);
  import mdd_pkg::*;

  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (chars_i[i] >= ASCII_ZERO && chars_i[i] <= ASCII_NINE) begin
        load_o.codes[i] = CODE_W'(chars_i[i] - ASCII_ZERO);
        load_o.blank[i] = 1'b0;
      end else begin
        load_o.codes[i] = BLANK_CODE;
        load_o.blank[i] = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mdd_scan_core.sv
// scan state, pwm phase timer and brightness registers
// depends on mdd_pkg; fed by mdd_char_decode through the top level
`default_nettype none

module mdd_scan_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mdd_pkg::cfg_wr_t cfg_i,
  input  logic             step_i,
  input  logic             cmd_i,
  input  mdd_pkg::load_t   load_i,
  output mdd_pkg::res_t    res_o
);
  import mdd_pkg::*;

  logic                               phase_par_q, phase_par_d;
  logic [DIG_W-1:0]                   digit_ptr_q, digit_ptr_d;
  logic [LEN_W-1:0]                   elapsed_q, elapsed_d;
  logic [LEN_W-1:0]                   phase_len_q, phase_len_d;
  logic [DIGIT_COUNT-1:0][CODE_W-1:0] codes_q, codes_d;
  logic [DIGIT_COUNT-1:0]             blank_q, blank_d;
  logic [CODE_W-1:0]                  cathode_q, cathode_d;
  logic [DIGIT_COUNT-1:0]             anode_q, anode_d;
  logic [DIGIT_COUNT-1:0][BRIGHT_W-1:0] bright_q, bright_d;
  logic                               disp_on_q, disp_on_d;

  logic [BRIGHT_W-1:0] cur_bright;
  logic [LEN_W:0]      elapsed_inc;
  logic                expire;

  assign cur_bright  = bright_q[digit_ptr_q];
  assign elapsed_inc = {1'b0, elapsed_q} + (LEN_W+1)'(1);
  assign expire      = elapsed_inc >= {1'b0, phase_len_q};

  always_comb begin
    phase_par_d = phase_par_q;
    digit_ptr_d = digit_ptr_q;
    elapsed_d   = elapsed_q;
    phase_len_d = phase_len_q;
    codes_d     = codes_q;
    blank_d     = blank_q;
    cathode_d   = cathode_q;
    anode_d     = anode_q;
    bright_d    = bright_q;
    disp_on_d   = disp_on_q;

    if (step_i) begin
      if (cmd_i == CMD_LOAD) begin
        codes_d = load_i.codes;
        blank_d = load_i.blank;
      end else if (disp_on_q) begin
        elapsed_d = elapsed_inc[LEN_W-1:0];
        if (expire) begin
          elapsed_d = '0;
          if (!phase_par_q) begin
            // off phase: dark for the rest of the period, then next digit
            anode_d     = '0;
            phase_len_d = (LEN_W'(cur_bright) <= BRIGHT_MAX_L) ?
                          BRIGHT_MAX_L - LEN_W'(cur_bright) : '0;
            digit_ptr_d = digit_ptr_q + DIG_W'(1);
            phase_par_d = 1'b1;
          end else begin
            cathode_d   = codes_q[digit_ptr_q];
            anode_d     = (DIGIT_COUNT'(1) << digit_ptr_q) & ~blank_q;
            phase_len_d = LEN_W'(cur_bright);
            phase_par_d = 1'b0;
          end
        end
      end
    end

    if (cfg_i.we) begin
      unique case (cfg_i.addr) inside
        REG_BRIGHT0, REG_BRIGHT1, REG_BRIGHT2, REG_BRIGHT3: begin
          if (LEN_W'(cfg_i.data) <= BRIGHT_MAX_L) begin
            bright_d[cfg_i.addr[DIG_W-1:0]] = cfg_i.data;
          end
        end
        REG_DISPLAY_ON: begin
          if (cfg_i.data[0]) begin
            disp_on_d   = 1'b1;
            digit_ptr_d = '0;
            elapsed_d   = '0;
          end else begin
            disp_on_d = 1'b0;
            anode_d   = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_par_q <= 1'b0;
      digit_ptr_q <= '0;
      elapsed_q   <= '0;
      phase_len_q <= '0;
      codes_q     <= '0;
      blank_q     <= '0;
      cathode_q   <= '0;
      anode_q     <= '0;
      bright_q    <= {DIGIT_COUNT{BRIGHT_RST}};
      disp_on_q   <= 1'b1;
    end else begin
      phase_par_q <= phase_par_d;
      digit_ptr_q <= digit_ptr_d;
      elapsed_q   <= elapsed_d;
      phase_len_q <= phase_len_d;
      codes_q     <= codes_d;
      blank_q     <= blank_d;
      cathode_q   <= cathode_d;
      anode_q     <= anode_d;
      bright_q    <= bright_d;
      disp_on_q   <= disp_on_d;
    end
  end

  // result carries the latch values after this beat
  assign res_o.cathode_code = cathode_d;
  assign res_o.anode_lines  = anode_d;
  assign res_o.scan_digit   = digit_ptr_d;

endmodule

`default_nettype wire

FILE: hdl/multiplexed_digit_display_pwm_top.sv
// top level of the four-digit multiplexed display scanner with pwm dimming
// depends on mdd_pkg, mdd_char_decode and mdd_scan_core
`default_nettype none

// channel  dir  signals                     contents
// s_axis   in   tvalid tready tdata tuser   tick or load of four characters
// m_axis   out  tvalid tready tdata         latch state after each beat
// cfg      in   we addr data                brightness 0..3, display_on
//
// one beat per clock sustained while m_axis_tready is high; the path is an
// input register, the scan/timer update logic, then a result register
// the input register frees whenever the result register is empty or taken,
// so a stalled result still lets one more beat in
// reset brings "0000" on screen, full brightness, scanning on, first tick
// starts the off phase of digit 0

module multiplexed_digit_display_pwm_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [7:0]  cfg_data_i,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // char0 [7:0], char1, char2, char3 [31:24]
  input  logic        s_axis_tuser,   // cmd: 0 tick, 1 load
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // cathode_code [7:0], anode_lines [11:8],
                                      // scan_digit [13:12], zero [15:14]
);
  import mdd_pkg::*;

  // input register
  logic                               in_vld_q, in_vld_d;
  logic                               in_cmd_q, in_cmd_d;
  logic [DIGIT_COUNT-1:0][CHAR_W-1:0] in_chars_q, in_chars_d;

  // result register
  logic out_vld_q, out_vld_d;
  res_t out_res_q, out_res_d;

  logic    advance;
  load_t   load;
  res_t    core_res;
  cfg_wr_t cfg;

  // an item moves on when the result slot is free or being emptied
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_comb begin
    in_vld_d   = in_vld_q;
    in_cmd_d   = in_cmd_q;
    in_chars_d = in_chars_q;
    if (advance) begin
      in_vld_d = 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_vld_d   = 1'b1;
      in_cmd_d   = s_axis_tuser;
      in_chars_d = s_axis_tdata;
    end

    out_vld_d = out_vld_q;
    out_res_d = out_res_q;
    if (advance) begin
      out_vld_d = 1'b1;
      out_res_d = core_res;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    in_cmd_q   <= in_cmd_d;
    in_chars_q <= in_chars_d;
    out_res_q  <= out_res_d;
  end

  assign cfg.we   = cfg_we_i;
  assign cfg.addr = cfg_addr_i;
  assign cfg.data = cfg_data_i;

  mdd_char_decode u_decode (
    .chars_i (in_chars_q),
    .load_o  (load)
  );

  mdd_scan_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (advance),
    .cmd_i  (in_cmd_q),
    .load_i (load),
    .res_o  (core_res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_res_q.scan_digit, out_res_q.anode_lines,
                          out_res_q.cathode_code};

endmodule

`default_nettype wire
